[design/rsis_pkg.sv]
// ---------------------------------------------------------------------------
// Ray/sphere intersection package
// Shared widths and types for the ray/sphere intersection and shading block.
// ---------------------------------------------------------------------------
package rsis_pkg;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    // Width of a vector component after it has been prescaled for normalising.
    localparam int MAG_W = 31;

    // Width of the sum of three squared prescaled components and of its root.
    localparam int SUMSQ_W = 64;
    localparam int LEN_W   = 32;

    // Stream payload widths.
    localparam int IN_DATA_W  = 344;
    localparam int OUT_DATA_W = 128;

    // Flags that leave the normaliser with each vector.
    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } norm_flags_t;

endpackage

[design/rsis_sqrt.sv]
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit resolved per register stage.
// ---------------------------------------------------------------------------
module rsis_sqrt #(
    parameter int NW     = 64,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NW-1:0]     radicand,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NW/2-1:0]   root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int ITER = NW / 2;

    logic [ITER:0]       valid_reg;
    logic [NW-1:0]       n_reg    [ITER+1];
    logic [NW-1:0]       r_reg    [ITER+1];
    logic [SIDE_W-1:0]   side_reg [ITER+1];
    logic [NW-1:0]       trial    [ITER];
    logic [ITER-1:0]     take;

    always_comb
    begin
        for (int k = 0; k < ITER; k++)
        begin
            trial[k] = r_reg[k] + (NW'(1) << (NW - 2 - 2 * k));
            take[k]  = n_reg[k] >= trial[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[ITER-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]    <= radicand;
            r_reg[0]    <= '0;
            side_reg[0] <= in_side;
            for (int k = 0; k < ITER; k++)
            begin
                if (take[k])
                begin
                    n_reg[k+1] <= n_reg[k] - trial[k];
                    r_reg[k+1] <= (r_reg[k] >> 1) + (NW'(1) << (NW - 2 - 2 * k));
                end
                else
                begin
                    n_reg[k+1] <= n_reg[k];
                    r_reg[k+1] <= r_reg[k] >> 1;
                end
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[ITER];
    assign root      = r_reg[ITER][ITER-1:0];
    assign out_side  = side_reg[ITER];

endmodule

[design/rsis_div.sv]
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned division of several numerators by one divisor, one quotient bit
// per register stage, for quotients known to stay below 2^QB.
// ---------------------------------------------------------------------------
module rsis_div #(
    parameter int LANES  = 3,
    parameter int NW     = 48,
    parameter int DW     = 32,
    parameter int QB     = 17,
    parameter int SIDE_W = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [LANES-1:0][NW-1:0]   num,
    input  logic [DW-1:0]              divisor,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [LANES-1:0][QB-1:0]   quot,
    output logic [SIDE_W-1:0]          out_side
);

    localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

    logic [QB:0]                   valid_reg;
    logic [LANES-1:0][NW-1:0]      rem_reg  [QB+1];
    logic [LANES-1:0][QB-1:0]      q_reg    [QB+1];
    logic [DW-1:0]                 d_reg    [QB+1];
    logic [SIDE_W-1:0]             side_reg [QB+1];
    logic [CW-1:0]                 shd      [QB];
    logic [LANES-1:0]              ge       [QB];

    always_comb
    begin
        for (int k = 0; k < QB; k++)
        begin
            shd[k] = CW'(d_reg[k]) << (QB - 1 - k);
            for (int l = 0; l < LANES; l++)
            begin
                ge[k][l] = CW'(rem_reg[k][l]) >= shd[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QB-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num;
            q_reg[0]    <= '0;
            d_reg[0]    <= divisor;
            side_reg[0] <= in_side;
            for (int k = 0; k < QB; k++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k+1][l] <= ge[k][l] ? rem_reg[k][l] - shd[k][NW-1:0]
                                                : rem_reg[k][l];
                    q_reg[k+1][l]   <= {q_reg[k][l][QB-2:0], ge[k][l]};
                end
                d_reg[k+1]    <= d_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[QB];
    assign quot      = q_reg[QB];
    assign out_side  = side_reg[QB];

endmodule

[design/rsis_norm.sv]
// ---------------------------------------------------------------------------
// Vector normaliser front end
// Takes magnitudes and signs of a 3-vector, prescales them so the largest
// lies in [2^30, 2^31), and returns the floor length of the scaled vector.
// ---------------------------------------------------------------------------
module rsis_norm #(
    parameter int VW     = 32,
    parameter int SIDE_W = 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [2:0][VW-1:0]                   vec,
    input  logic [SIDE_W-1:0]                    in_side,
    output logic                                 out_valid,
    output logic [2:0][rsis_pkg::MAG_W-1:0]      mag,
    output logic [rsis_pkg::LEN_W-1:0]           len,
    output rsis_pkg::norm_flags_t                flags,
    output logic [SIDE_W-1:0]                    out_side
);

    localparam int MW  = rsis_pkg::MAG_W;
    localparam int LZW = $clog2(VW);
    localparam int SQW = rsis_pkg::SUMSQ_W;

    typedef struct packed {
        logic [SIDE_W-1:0]     side;
        logic [2:0][MW-1:0]    mag;
        rsis_pkg::norm_flags_t flags;
    } root_side_t;

    logic [4:0]               valid_reg;
    logic [2:0][VW-1:0]       a_next;
    logic [VW-1:0]            m_next;
    logic [2:0][VW-1:0]       a1_reg, a2_reg;
    logic [VW-1:0]            m1_reg;
    logic [2:0]               neg1_reg;
    logic [LZW-1:0]           lz_next, lz2_reg;
    rsis_pkg::norm_flags_t    f2_reg, f3_reg, f4_reg, f5_reg;
    logic [2:0][VW-1:0]       sh_next;
    logic [2:0][MW-1:0]       mag3_reg, mag4_reg, mag5_reg;
    logic [2:0][2*MW-1:0]     sq4_reg;
    logic [SQW-1:0]           sum5_reg;
    logic [SIDE_W-1:0]        side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    root_side_t               rs_in, rs_out;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_next[i] = vec[i][VW-1] ? -vec[i] : vec[i];
        end
        m_next = a_next[0];
        if (a_next[1] > m_next)
        begin
            m_next = a_next[1];
        end
        if (a_next[2] > m_next)
        begin
            m_next = a_next[2];
        end
    end

    // Leading-zero count of the largest magnitude.
    always_comb
    begin
        lz_next = '0;
        for (int i = 0; i < VW; i++)
        begin
            if (m1_reg[i])
            begin
                lz_next = LZW'(VW - 1 - i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sh_next[i] = a2_reg[i] << lz2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= a_next;
            m1_reg    <= m_next;
            neg1_reg  <= {vec[2][VW-1], vec[1][VW-1], vec[0][VW-1]};
            side1_reg <= in_side;

            a2_reg      <= a1_reg;
            lz2_reg     <= lz_next;
            f2_reg.neg  <= neg1_reg;
            f2_reg.zero <= (m1_reg == '0);
            side2_reg   <= side1_reg;

            for (int i = 0; i < 3; i++)
            begin
                mag3_reg[i] <= sh_next[i][VW-1 -: MW];
                sq4_reg[i]  <= mag3_reg[i] * mag3_reg[i];
            end
            f3_reg    <= f2_reg;
            side3_reg <= side2_reg;

            mag4_reg  <= mag3_reg;
            f4_reg    <= f3_reg;
            side4_reg <= side3_reg;

            sum5_reg  <= SQW'(sq4_reg[0]) + SQW'(sq4_reg[1]) + SQW'(sq4_reg[2]);
            mag5_reg  <= mag4_reg;
            f5_reg    <= f4_reg;
            side5_reg <= side4_reg;
        end
    end

    assign rs_in.side  = side5_reg;
    assign rs_in.mag   = mag5_reg;
    assign rs_in.flags = f5_reg;

    rsis_sqrt #(
        .NW     (SQW),
        .SIDE_W ($bits(root_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid_reg[4]),
        .radicand  (sum5_reg),
        .in_side   (rs_in),
        .out_valid (out_valid),
        .root      (len),
        .out_side  (rs_out)
    );

    assign mag      = rs_out.mag;
    assign flags    = rs_out.flags;
    assign out_side = rs_out.side;

endmodule

[design/ray_sphere_intersect_shade_top.sv]
// ---------------------------------------------------------------------------
// Ray/sphere intersection and height shading
// Fully pipelined: one ray and sphere per transfer in, one result out.
// ---------------------------------------------------------------------------
// The block accepts one ray/sphere transfer every clock cycle while the output
// is not stalled and returns one result transfer per input, in order. The two
// bit-per-stage square roots and the two bit-per-stage dividers normalise the
// ray direction and the surface normal. The whole pipeline advances together
// whenever the output register is empty or is being taken, so a stalled result
// holds every stage and nothing is dropped or repeated. All arithmetic is
// signed fixed point with FRAC_BITS fraction bits (Q16.16 by default); a miss
// (zero direction, sphere off the ray, or sphere entirely behind the origin)
// returns hit clear and all other fields zero. The hit point saturates to 32
// bits; the shading factor is (normal.y + 1) / 2 applied to each 8-bit channel
// with truncation.
// ---------------------------------------------------------------------------
module ray_sphere_intersect_shade_top #(
    parameter int FRAC_BITS = rsis_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y,
    // center_z (32 bits each), radius (31), sphere_colour (24), one zero pad bit
    input  logic [rsis_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // hit (1), hit_x, hit_y, hit_z (32 bits each), shaded_colour (24), zero pad
    output logic [rsis_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int F    = FRAC_BITS;
    localparam int MW   = rsis_pkg::MAG_W;
    localparam int UW   = F + 2;          // signed unit component
    localparam int QB   = F + 1;          // unsigned quotient bits
    localparam int OCW  = 33;
    localparam int PRW  = OCW + UW;
    localparam int DSW  = PRW + 2;
    localparam int TW   = 37;
    localparam int PMW  = UW + TW;
    localparam int PW   = 38;
    localparam int SW   = 38;
    localparam int USW  = UW + SW;
    localparam int HW   = 39;
    localparam int NVW  = 40;
    localparam int DNW  = MW + F + 1;
    localparam int CFW  = F + 1;
    localparam int RW   = 2 * MW;

    localparam logic signed [HW-1:0] SAT_MAX = HW'(32'sh7FFFFFFF);
    localparam logic signed [HW-1:0] SAT_MIN = HW'(32'sh80000000);

    typedef logic [2:0][31:0] vec32_t;

    typedef struct packed {
        vec32_t      org;
        vec32_t      cen;
        logic [30:0] r;
        logic [23:0] col;
    } ray_side_t;

    typedef struct packed {
        ray_side_t             ray;
        rsis_pkg::norm_flags_t flags;
    } div_side_t;

    typedef struct packed {
        vec32_t              org;
        vec32_t              cen;
        logic [30:0]         r;
        logic [23:0]         col;
        logic [2:0][UW-1:0]  u;
        logic [2:0][OCW-1:0] oc;
        logic [TW-1:0]       t;
        logic                miss;
    } carry_t;

    typedef struct packed {
        vec32_t      hp;
        logic [23:0] col;
        logic        miss;
    } shade_side_t;

    typedef struct packed {
        shade_side_t           sh;
        rsis_pkg::norm_flags_t flags;
    } div2_side_t;

    // Global advance: the output register is empty or its transfer completes.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------------------------------------------------------
    // Input unpacking and direction normalisation
    // ---------------------------------------------------------------
    vec32_t    in_org, in_dir, in_cen;
    ray_side_t in_side;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_org[i] = s_tdata[32*i +: 32];
            in_dir[i] = s_tdata[96 + 32*i +: 32];
            in_cen[i] = s_tdata[192 + 32*i +: 32];
        end
        in_side.org = in_org;
        in_side.cen = in_cen;
        in_side.r   = s_tdata[318:288];
        in_side.col = s_tdata[342:319];
    end

    logic                          n1_valid;
    logic [2:0][MW-1:0]            n1_mag;
    logic [rsis_pkg::LEN_W-1:0]    n1_len;
    rsis_pkg::norm_flags_t         n1_flags;
    ray_side_t                     n1_side;

    rsis_norm #(
        .VW     (32),
        .SIDE_W ($bits(ray_side_t))
    ) u_norm_dir (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .vec       (in_dir),
        .in_side   (in_side),
        .out_valid (n1_valid),
        .mag       (n1_mag),
        .len       (n1_len),
        .flags     (n1_flags),
        .out_side  (n1_side)
    );

    // Each component becomes round(|a| * 2^F / len).
    logic [2:0][DNW-1:0] d1_num;
    div_side_t           d1_in_side, d1_side;
    logic                d1_valid;
    logic [2:0][QB-1:0]  d1_q;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_num[i] = (DNW'(n1_mag[i]) << F) + DNW'(n1_len >> 1);
        end
        d1_in_side.ray   = n1_side;
        d1_in_side.flags = n1_flags;
    end

    rsis_div #(
        .LANES  (3),
        .NW     (DNW),
        .DW     (rsis_pkg::LEN_W),
        .QB     (QB),
        .SIDE_W ($bits(div_side_t))
    ) u_div_dir (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n1_valid),
        .num       (d1_num),
        .divisor   (n1_len),
        .in_side   (d1_in_side),
        .out_valid (d1_valid),
        .quot      (d1_q),
        .out_side  (d1_side)
    );

    // ---------------------------------------------------------------
    // Projection and perpendicular distance
    // ---------------------------------------------------------------
    logic v_b_reg, v_c_reg, v_d_reg, v_e_reg, v_f_reg, v_g_reg, v_h_reg, v_i_reg;
    logic v_j_reg, v_k_reg, v_l_reg, v_m_reg, v_n_reg;
    logic m_tvalid_reg;

    carry_t cb_next, cb_reg, cc_reg, cd_next, cd_reg, ce_reg, cf_next, cf_reg;
    carry_t cg_reg, ch_reg, ci_next, ci_reg, c_sq, cj_next, cj_reg, ck_reg, cl_reg;

    logic signed [PRW-1:0] prod_next [3];
    logic signed [PRW-1:0] prod_reg  [3];
    logic signed [DSW-1:0] dot_sum;
    logic signed [PMW-1:0] pm_next   [3];
    logic signed [PMW-1:0] pm_reg    [3];
    logic signed [PMW-1:0] pm_rnd    [3];
    logic signed [PW-1:0]  perp      [3];
    logic [PW-1:0]         perp_abs  [3];
    logic [2:0]            perp_over;
    logic [2:0][30:0]      ap_reg;
    logic [2:0][RW-1:0]    sq_reg;
    logic [RW-1:0]         r2_reg, r2h_reg;
    logic [63:0]           psq_reg;
    logic [RW-1:0]         diff_next, diff_reg;
    logic [UW-1:0]         qext;

    always_comb
    begin
        cb_next      = '0;
        cb_next.org  = d1_side.ray.org;
        cb_next.cen  = d1_side.ray.cen;
        cb_next.r    = d1_side.ray.r;
        cb_next.col  = d1_side.ray.col;
        cb_next.miss = d1_side.flags.zero;
        qext         = '0;
        for (int i = 0; i < 3; i++)
        begin
            qext          = UW'(d1_q[i]);
            cb_next.u[i]  = d1_side.flags.neg[i] ? -qext : qext;
            cb_next.oc[i] = OCW'($signed(d1_side.ray.cen[i]))
                          - OCW'($signed(d1_side.ray.org[i]));
        end
    end

    // The products are taken one stage ahead so that they meet their own ray.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = $signed(cb_reg.oc[i]) * $signed(cb_reg.u[i]);
        end
        dot_sum = DSW'(prod_reg[0]) + DSW'(prod_reg[1]) + DSW'(prod_reg[2])
                + (DSW'(1) <<< (F - 1));
        cd_next   = cc_reg;
        cd_next.t = TW'(dot_sum >>> F);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pm_next[i]   = $signed(cd_reg.u[i]) * $signed(cd_reg.t);
            pm_rnd[i]    = (pm_reg[i] + (PMW'(1) <<< (F - 1))) >>> F;
            perp[i]      = PW'($signed(ce_reg.oc[i])) - PW'(pm_rnd[i]);
            perp_abs[i]  = perp[i][PW-1] ? -perp[i] : perp[i];
            perp_over[i] = perp_abs[i] > PW'(ce_reg.r);
        end
        cf_next      = ce_reg;
        cf_next.miss = ce_reg.miss | (|perp_over);
    end

    always_comb
    begin
        ci_next      = ch_reg;
        ci_next.miss = ch_reg.miss | (psq_reg > 64'(r2h_reg));
        diff_next    = r2h_reg - psq_reg[RW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cb_reg <= cb_next;
            cc_reg <= cb_reg;
            cd_reg <= cd_next;
            ce_reg <= cd_reg;
            cf_reg <= cf_next;
            cg_reg <= cf_reg;
            ch_reg <= cg_reg;
            ci_reg <= ci_next;
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= prod_next[i];
                pm_reg[i]   <= pm_next[i];
                ap_reg[i]   <= perp_abs[i][30:0];
                sq_reg[i]   <= ap_reg[i] * ap_reg[i];
            end
            r2_reg   <= cf_reg.r * cf_reg.r;
            psq_reg  <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            r2h_reg  <= r2_reg;
            diff_reg <= diff_next;
        end
    end

    // Half chord length: floor(sqrt(r^2 - |p|^2)).
    logic          sq_valid;
    logic [MW-1:0] sq_off;

    rsis_sqrt #(
        .NW     (RW),
        .SIDE_W ($bits(carry_t))
    ) u_sqrt_off (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_i_reg),
        .radicand  (diff_reg),
        .in_side   (ci_reg),
        .out_valid (sq_valid),
        .root      (sq_off),
        .out_side  (c_sq)
    );

    // ---------------------------------------------------------------
    // Root selection, hit point and normal vector
    // ---------------------------------------------------------------
    logic signed [SW-1:0]  t_ext, off_ext, near_t, far_t, s_next, s_reg;
    logic signed [USW-1:0] us_next [3];
    logic signed [USW-1:0] us_reg  [3];
    logic signed [USW-1:0] us_rnd  [3];
    logic signed [HW-1:0]  hp_next [3];
    logic signed [HW-1:0]  hp_reg  [3];
    logic [2:0][NVW-1:0]   nv_next, nv_reg;
    shade_side_t           shm_next, shm_reg;

    always_comb
    begin
        t_ext   = SW'($signed(c_sq.t));
        off_ext = SW'(sq_off);
        near_t  = t_ext - off_ext;
        far_t   = t_ext + off_ext;
        s_next  = near_t[SW-1] ? far_t : near_t;
        cj_next      = c_sq;
        cj_next.miss = c_sq.miss | far_t[SW-1];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            us_next[i] = $signed(cj_reg.u[i]) * s_reg;
            us_rnd[i]  = (us_reg[i] + (USW'(1) <<< (F - 1))) >>> F;
            hp_next[i] = HW'($signed(ck_reg.org[i])) + HW'(us_rnd[i]);
            nv_next[i] = NVW'(hp_reg[i]) - NVW'($signed(cl_reg.cen[i]));
            if (hp_reg[i] > SAT_MAX)
            begin
                shm_next.hp[i] = 32'h7FFF_FFFF;
            end
            else if (hp_reg[i] < SAT_MIN)
            begin
                shm_next.hp[i] = 32'h8000_0000;
            end
            else
            begin
                shm_next.hp[i] = hp_reg[i][31:0];
            end
        end
        shm_next.col  = cl_reg.col;
        shm_next.miss = cl_reg.miss;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cj_reg <= cj_next;
            s_reg  <= s_next;
            ck_reg <= cj_reg;
            cl_reg <= ck_reg;
            for (int i = 0; i < 3; i++)
            begin
                us_reg[i] <= us_next[i];
                hp_reg[i] <= hp_next[i];
            end
            nv_reg  <= nv_next;
            shm_reg <= shm_next;
        end
    end

    // ---------------------------------------------------------------
    // Normal normalisation (only the y component is divided out)
    // ---------------------------------------------------------------
    logic                          n2_valid;
    logic [2:0][MW-1:0]            n2_mag;
    logic [rsis_pkg::LEN_W-1:0]    n2_len;
    rsis_pkg::norm_flags_t         n2_flags;
    shade_side_t                   n2_side;

    rsis_norm #(
        .VW     (NVW),
        .SIDE_W ($bits(shade_side_t))
    ) u_norm_nrm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_m_reg),
        .vec       (nv_reg),
        .in_side   (shm_reg),
        .out_valid (n2_valid),
        .mag       (n2_mag),
        .len       (n2_len),
        .flags     (n2_flags),
        .out_side  (n2_side)
    );

    logic [0:0][DNW-1:0] d2_num;
    div2_side_t          d2_in_side, d2_side;
    logic                d2_valid;
    logic [0:0][QB-1:0]  d2_q;

    always_comb
    begin
        d2_num[0]        = (DNW'(n2_mag[1]) << F) + DNW'(n2_len >> 1);
        d2_in_side.sh    = n2_side;
        d2_in_side.flags = n2_flags;
    end

    rsis_div #(
        .LANES  (1),
        .NW     (DNW),
        .DW     (rsis_pkg::LEN_W),
        .QB     (QB),
        .SIDE_W ($bits(div2_side_t))
    ) u_div_nrm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n2_valid),
        .num       (d2_num),
        .divisor   (n2_len),
        .in_side   (d2_in_side),
        .out_valid (d2_valid),
        .quot      (d2_q),
        .out_side  (d2_side)
    );

    // ---------------------------------------------------------------
    // Shading coefficient and output register
    // ---------------------------------------------------------------
    logic [UW-1:0]     ny_mag, ny, coef_sum;
    logic [CFW-1:0]    coef_reg;
    shade_side_t       shn_reg;
    logic [CFW+7:0]    chan_prod [3];
    logic [23:0]       shade_col;
    logic [rsis_pkg::OUT_DATA_W-1:0] m_tdata_next, m_tdata_reg;

    always_comb
    begin
        ny_mag = UW'(d2_q[0]);
        if (d2_side.flags.zero)
        begin
            ny = '0;
        end
        else if (d2_side.flags.neg[1])
        begin
            ny = -ny_mag;
        end
        else
        begin
            ny = ny_mag;
        end
        // ny lies in [-2^F, 2^F], so the sum is never negative.
        coef_sum = ny + (UW'(1) << F);
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            chan_prod[j]       = (CFW+8)'(shn_reg.col[8*j +: 8]) * (CFW+8)'(coef_reg);
            shade_col[8*j +: 8] = chan_prod[j][F+7:F];
        end
        if (shn_reg.miss)
        begin
            m_tdata_next = '0;
        end
        else
        begin
            m_tdata_next = {7'b0, shade_col, shn_reg.hp[2], shn_reg.hp[1],
                            shn_reg.hp[0], 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_reg    <= coef_sum[F+1:1];
            shn_reg     <= d2_side.sh;
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_b_reg      <= 1'b0;
            v_c_reg      <= 1'b0;
            v_d_reg      <= 1'b0;
            v_e_reg      <= 1'b0;
            v_f_reg      <= 1'b0;
            v_g_reg      <= 1'b0;
            v_h_reg      <= 1'b0;
            v_i_reg      <= 1'b0;
            v_j_reg      <= 1'b0;
            v_k_reg      <= 1'b0;
            v_l_reg      <= 1'b0;
            v_m_reg      <= 1'b0;
            v_n_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_b_reg      <= d1_valid;
            v_c_reg      <= v_b_reg;
            v_d_reg      <= v_c_reg;
            v_e_reg      <= v_d_reg;
            v_f_reg      <= v_e_reg;
            v_g_reg      <= v_f_reg;
            v_h_reg      <= v_g_reg;
            v_i_reg      <= v_h_reg;
            v_j_reg      <= sq_valid;
            v_k_reg      <= v_j_reg;
            v_l_reg      <= v_k_reg;
            v_m_reg      <= v_l_reg;
            v_n_reg      <= d2_valid;
            m_tvalid_reg <= v_n_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A miss carries no hit point and no colour.
    a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[120:1] == '0))
        else $error("miss result carries non-zero fields");

    // The chosen distance along a surviving ray is never negative.
    a_root_ahead : assert property (@(posedge clk) disable iff (!rst_n)
        (v_j_reg && !cj_reg.miss) |-> !s_reg[SW-1])
        else $error("selected root lies behind the origin");

    // The shading factor never exceeds one.
    a_coef_range : assert property (@(posedge clk) disable iff (!rst_n)
        v_n_reg |-> (coef_reg <= (CFW'(1) << F)))
        else $error("shading coefficient above one");

endmodule

[tb/ray_sphere_intersect_shade_top_tb.sv]
// ---------------------------------------------------------------------------
// Ray/sphere intersection and shading testbench
// Streams rays and spheres into the block with random bursts and gaps while the
// output side stalls on its own pattern. An internal fixed-point predictor works
// out each hit point and shaded colour, and every result transfer is checked in
// order against it, field by field.
// ---------------------------------------------------------------------------
module ray_sphere_intersect_shade_top_tb;

    localparam int  FB       = rsis_pkg::FRAC_BITS_DEF;
    localparam int  ONE      = 1 << FB;
    localparam int  LATENCY  = 2 * FB + 126;
    localparam int  N_RANDOM = 1530;
    localparam int  DRAIN_AT = 700;

    typedef longint vec3_t [3];

    // One ray and one sphere, as carried by an input transfer.
    typedef struct {
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        logic signed [31:0] cen [3];
        logic [30:0]        radius;
        logic [23:0]        colour;
    } ray_item_t;

    // One intersection result, as carried by an output transfer.
    typedef struct {
        logic               hit;
        logic signed [31:0] hp [3];
        logic [23:0]        colour;
    } hit_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [rsis_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [rsis_pkg::OUT_DATA_W-1:0] m_tdata;

    ray_item_t   ray_queue [$];
    hit_result_t expected_hits [$];
    ray_item_t   cur_ray;
    int          rays_sent;
    int          errors;
    bit          stimulus_done;

    ray_sphere_intersect_shade_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Fields are packed from the lowest bit: origin, direction, centre, radius,
    // colour, with one zero pad bit on top.
    function automatic logic [rsis_pkg::IN_DATA_W-1:0] pack_ray(input ray_item_t r);
        logic [rsis_pkg::IN_DATA_W-1:0] d;
        d = '0;
        for (int i = 0; i < 3; i++)
        begin
            d[32*i +: 32]       = r.org[i];
            d[96 + 32*i +: 32]  = r.dir[i];
            d[192 + 32*i +: 32] = r.cen[i];
        end
        d[288 +: 31] = r.radius;
        d[319 +: 24] = r.colour;
        return d;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b + (longint'(1) << (FB - 1))) >>> FB;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = longint'(1) << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n    -= root + b;
                root  = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    // Normalises a vector: magnitudes are prescaled into [2^30, 2^31) before
    // the root is taken. Returns 0 for a zero vector.
    function automatic bit normalise(input vec3_t v, output vec3_t u);
        longint unsigned a [3];
        longint unsigned m;
        longint unsigned len;
        longint unsigned q;
        bit              neg [3];
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            a[i]   = neg[i] ? -v[i] : v[i];
            if (a[i] > m)
                m = a[i];
        end
        u = '{0, 0, 0};
        if (m == 0)
            return 1'b0;
        while (m >= (longint'(1) << 31))
        begin
            for (int i = 0; i < 3; i++)
                a[i] >>= 1;
            m >>= 1;
        end
        while (m < (longint'(1) << 30))
        begin
            for (int i = 0; i < 3; i++)
                a[i] <<= 1;
            m <<= 1;
        end
        len = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        for (int i = 0; i < 3; i++)
        begin
            q    = ((a[i] << FB) + (len >> 1)) / len;
            u[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic hit_result_t intersect_and_shade(input ray_item_t r);
        hit_result_t     res;
        vec3_t           org, dir, cen, u, oc, hp, nv, nu;
        longint          t, s, off, p, coef;
        longint unsigned ap, psq, r2;
        logic [7:0]      ch;
        res.hit    = 1'b0;
        res.hp     = '{0, 0, 0};
        res.colour = '0;
        for (int i = 0; i < 3; i++)
        begin
            org[i] = r.org[i];
            dir[i] = r.dir[i];
            cen[i] = r.cen[i];
            oc[i]  = cen[i] - org[i];
        end
        if (!normalise(dir, u))
            return res;
        t = (oc[0] * u[0] + oc[1] * u[1] + oc[2] * u[2] + (longint'(1) << (FB - 1))) >>> FB;
        psq = 0;
        for (int i = 0; i < 3; i++)
        begin
            p  = oc[i] - fx_mul(u[i], t);
            ap = p < 0 ? -p : p;
            if (ap > r.radius)
                return res;
            psq += ap * ap;
        end
        r2 = longint'(r.radius) * longint'(r.radius);
        if (psq > r2)
            return res;
        off = int_sqrt(r2 - psq);
        if (t - off >= 0)
            s = t - off;
        else if (t + off >= 0)
            s = t + off;
        else
            return res;
        for (int i = 0; i < 3; i++)
        begin
            hp[i] = org[i] + fx_mul(u[i], s);
            nv[i] = hp[i] - cen[i];
            if (hp[i] > 64'sh7FFF_FFFF)
                res.hp[i] = 32'sh7FFF_FFFF;
            else if (hp[i] < -64'sh8000_0000)
                res.hp[i] = 32'sh8000_0000;
            else
                res.hp[i] = hp[i][31:0];
        end
        void'(normalise(nv, nu));
        coef = (nu[1] + ONE) >>> 1;
        for (int i = 0; i < 3; i++)
        begin
            ch = r.colour[8*i +: 8];
            res.colour[8*i +: 8] = 8'((longint'(ch) * coef) >>> FB);
        end
        res.hit = 1'b1;
        return res;
    endfunction

    function automatic ray_item_t make_ray(input int ox, oy, oz, dx, dy, dz,
                                           input int cx, cy, cz,
                                           input logic [30:0] rad,
                                           input logic [23:0] col);
        ray_item_t r;
        r.org = '{ox, oy, oz};
        r.dir = '{dx, dy, dz};
        r.cen = '{cx, cy, cz};
        r.radius = rad;
        r.colour = col;
        return r;
    endfunction

    // A signed value of random magnitude, so that small and large scales occur.
    function automatic int rand_scaled(input int max_bits);
        int v;
        v = $urandom;
        return v >>> (32 - $urandom_range(max_bits, 1));
    endfunction

    // Mostly rays aimed at their sphere with random offsets, so that near and
    // far roots, grazing misses and spheres behind the origin all come up.
    // The rest is raw noise over the whole range of every field.
    function automatic ray_item_t random_ray();
        ray_item_t r;
        int        k;
        if ($urandom_range(9) == 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r.org[i] = $urandom;
                r.dir[i] = $urandom;
                r.cen[i] = $urandom;
            end
            r.radius = 31'($urandom);
            r.colour = 24'($urandom);
            return r;
        end
        k = $urandom_range(6);
        for (int i = 0; i < 3; i++)
        begin
            r.org[i] = rand_scaled(28);
            r.dir[i] = rand_scaled(31);
            if ($urandom_range(3) == 0)
                r.dir[i] = 0;
            r.cen[i] = r.org[i] + ((k == 6) ? -(r.dir[i] >>> 4) : (r.dir[i] >>> k))
                       + rand_scaled(20);
        end
        r.radius = 31'($urandom >> $urandom_range(15, 1));
        r.colour = 24'($urandom);
        return r;
    endfunction

    initial
    begin
        // Head-on hit, top hit from above, sphere behind, origin inside.
        ray_queue.push_back(make_ray(0, 0, 0, 0, 0, ONE, 0, 0, 10*ONE, 2*ONE, 24'hFFFFFF));
        ray_queue.push_back(make_ray(0, 5*ONE, 0, 0, -3*ONE, 0, 0, 0, 0, ONE, 24'h80C0FF));
        ray_queue.push_back(make_ray(0, 0, 0, 0, 0, ONE, 0, 0, -10*ONE, 2*ONE, 24'h123456));
        ray_queue.push_back(make_ray(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, 3*ONE, 24'hABCDEF));
        // Zero direction.
        ray_queue.push_back(make_ray(0, 0, 0, 0, 0, 0, 0, 0, ONE, 4*ONE, 24'hFFFFFF));
        // Perpendicular beyond the radius, one component only and combined.
        ray_queue.push_back(make_ray(0, 0, 0, 0, 0, ONE, 5*ONE, 0, 10*ONE, ONE, 24'hFF00FF));
        ray_queue.push_back(make_ray(0, 0, 0, 0, 0, ONE, ONE, ONE, 10*ONE, ONE + ONE/4,
                                     24'h00FF00));
        // Zero radius on the ray: the hit point lands on the centre.
        ray_queue.push_back(make_ray(0, 0, 0, 0, 0, 7, 0, 0, 5*ONE, 0, 24'hFFFFFF));
        // Bottom of a sphere hit from below, normal pointing down.
        ray_queue.push_back(make_ray(0, -9*ONE, 0, 0, ONE, 0, 0, 0, 0, 2*ONE, 24'hFFFFFF));
        // Saturating hit point and extreme field values.
        ray_queue.push_back(make_ray(32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 0, 0,
                                     32'h7FFFFFFF, 0, 0, 31'h7FFFFFFF, 24'hFFFFFF));
        ray_queue.push_back(make_ray(32'h80000000, 32'h80000000, 32'h80000000,
                                     32'h80000000, 32'h80000000, 32'h80000000,
                                     32'h80000000, 32'h80000000, 32'h80000000,
                                     31'h7FFFFFFF, 24'hFFFFFF));
        ray_queue.push_back(make_ray(32'h80000000, 0, 0, 32'h7FFFFFFF, 1, -1,
                                     32'h7FFFFFFF, 0, 0, 31'h7FFFFFFF, 24'h000000));
        ray_queue.push_back(make_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                     32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                     32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                     0, 24'h000000));
        ray_queue.push_back(make_ray(0, 0, 0, 1, 0, 0, 3, 0, 0, 1, 24'h010101));
        ray_queue.push_back(make_ray(0, 0, 0, -1, -1, -1, -ONE, -ONE, -ONE, ONE, 24'hFF8001));
        for (int i = 0; i < N_RANDOM; i++)
            ray_queue.push_back(random_ray());
    end

    // Driver: bursts of transfers separated by random gaps, with one full drain
    // part-way through the run.
    int  burst_left;
    int  gap_left;
    bit  in_fire;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_fire = 1'b0;
        else
            in_fire = s_tvalid && s_tready;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (s_tvalid && !in_fire)
        begin
            // Transfer still pending: hold it.
        end
        else if (gap_left > 0)
        begin
            s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (ray_queue.size() == 0
                 || (rays_sent == DRAIN_AT && expected_hits.size() != 0))
        begin
            s_tvalid <= 1'b0;
            if (ray_queue.size() == 0 && expected_hits.size() == 0 && !s_tvalid)
                stimulus_done <= 1'b1;
        end
        else
        begin
            cur_ray   = ray_queue.pop_front();
            s_tdata  <= pack_ray(cur_ray);
            s_tvalid <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(40, 1);
                gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
            end
            else
                burst_left <= burst_left - 1;
        end
    end

    // Receiver: the stall density is redrawn periodically from four modes, including
    // one that never stalls.
    int rx_cycle;
    int rx_mode;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_cycle <= 0;
            rx_mode  <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 300 == 0)
                rx_mode <= $urandom_range(3);
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(1);
                2: m_tready <= ($urandom_range(7) == 0);
                default: m_tready <= ((rx_cycle % 16) < 11);
            endcase
        end
    end

    // Monitor: predict on each accepted input transfer, check on each output one.
    initial
    begin
        rays_sent     = 0;
        errors        = 0;
        stimulus_done = 1'b0;
    end

    always @(posedge clk)
    begin
        ray_item_t   r;
        hit_result_t want;
        hit_result_t got;
        if (rst_n && s_tvalid && s_tready)
        begin
            r = cur_ray;
            expected_hits.push_back(intersect_and_shade(r));
            rays_sent++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.hit    = m_tdata[0];
            got.hp[0]  = m_tdata[1 +: 32];
            got.hp[1]  = m_tdata[33 +: 32];
            got.hp[2]  = m_tdata[65 +: 32];
            got.colour = m_tdata[97 +: 24];
            if (expected_hits.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                want = expected_hits.pop_front();
                if (got.hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, got.hit);
                    errors++;
                end
                for (int i = 0; i < 3; i++)
                    if (got.hp[i] !== want.hp[i])
                    begin
                        $error("hit_%s: expected %0d, got %0d", (i == 0) ? "x" :
                               (i == 1) ? "y" : "z", want.hp[i], got.hp[i]);
                        errors++;
                    end
                if (got.colour !== want.colour)
                begin
                    $error("shaded_colour: expected %h, got %h", want.colour, got.colour);
                    errors++;
                end
            end
        end
    end

    // End of run: once the queues have drained, keep running so that any surplus
    // result shows up before the final check.
    initial
    begin
        wait (stimulus_done);
        repeat (2 * LATENCY) @(posedge clk);
        if (errors == 0 && expected_hits.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule
